/* design/kernel_width_quantile_estimator_macros.svh */
// assertion macros for the kernel width quantile estimator
// used by the top level; no other dependencies
`ifndef KERNEL_WIDTH_QUANTILE_ESTIMATOR_MACROS_SVH
`define KERNEL_WIDTH_QUANTILE_ESTIMATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define KWQE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define KWQE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/kwqe_pkg.sv */
// shared types, constants and helpers for the kernel width estimator
// no dependencies
package kwqe_pkg;

    // default sizes
    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DIMS_DEF   = 16;

    // field and datapath widths
    localparam int COORD_W   = 16;
    localparam int LABEL_W   = 8;
    localparam int MASK_W    = 16;
    localparam int QUANT_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int SIGMA_W   = 19;
    localparam int GAMMA_W   = 32;
    localparam int DIST_W    = 37;
    localparam int MUL_W     = 19;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SQRT_IN_W = 38;
    localparam int DIV_N_W   = 40;
    localparam int DIV_D_W   = 38;

    // constants
    localparam logic [MASK_W-1:0]  MASK_RESET = 16'hFFFF;
    localparam logic [SIGMA_W-1:0] SIGMA_ONE  = 19'd256;
    localparam logic [SIGMA_W-1:0] SIGMA_MAX  = 19'h7FFFF;
    localparam logic [GAMMA_W-1:0] GAMMA_MAX  = 32'hFFFFFFFF;
    localparam logic [QUANT_W-1:0] QUANT_ONE  = 17'h10000;
    localparam logic [DIV_N_W-1:0] GAMMA_NUM  = 40'h80_0000_0000;
    localparam logic [FRAC_W:0]    FRAC_ONE   = 17'h10000;

    // function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE, S_FILL,
        S_B_START, S_B_LI, S_B_LJ, S_B_CMP, S_B_NEXT, S_B_DONE,
        S_C_RD, S_C_SQ, S_C_ACC,
        S_I_RD, S_I_CMP,
        S_Q_MUL, S_Q_IDX, S_Q_RDA, S_Q_SQA, S_Q_WA,
        S_Q_RDB, S_Q_SQB, S_Q_WB, S_Q_M1, S_Q_M2, S_Q_SUM,
        S_G_SQ, S_G_DIV, S_G_WAIT, S_OUT
    } state_t;

    // column enable: only the first sixteen columns can be selected
    function automatic logic col_en(input logic [MASK_W-1:0] mask, input logic [6:0] c);
        return (c < 7'd16) && mask[c[3:0]];
    endfunction

endpackage

/* design/kwqe_sqrt.sv */
// iterative square root, two radicand bits per cycle, rounded to nearest
// depends on kwqe_pkg
module kwqe_sqrt import kwqe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SQRT_IN_W-1:0] x,
    output logic                 done,
    output logic [SIGMA_W-1:0]   root
);
    localparam int STEPS = SQRT_IN_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = SIGMA_W + 2;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SQRT_IN_W-1:0] x_reg;
    logic [SIGMA_W-1:0]   root_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [SIGMA_W-1:0]   res_reg;

    logic [REM_W+1:0]     rem_sh;
    logic [REM_W+1:0]     trial;
    logic                 ge;
    logic [REM_W-1:0]     rem_new;
    logic [SIGMA_W-1:0]   root_new;
    logic [SIGMA_W:0]     rounded;

    // one restoring step
    always_comb
    begin
        rem_sh   = {rem_reg, x_reg[SQRT_IN_W-1 -: 2]};
        trial    = (REM_W+2)'({root_reg, 2'b01});
        ge       = rem_sh >= trial;
        rem_new  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_new = {root_reg[SIGMA_W-2:0], ge};
        rounded  = (SIGMA_W+1)'(root_new)
                 + (SIGMA_W+1)'(rem_new > REM_W'(root_new));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[SQRT_IN_W-3:0], 2'b00};
            root_reg <= root_new;
            rem_reg  <= rem_new;
            if (cnt_reg == CNT_W'(STEPS - 1))
                res_reg <= rounded[SIGMA_W] ? SIGMA_MAX : rounded[SIGMA_W-1:0];
        end
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

/* design/kwqe_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on kwqe_pkg
module kwqe_div import kwqe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] num,
    input  logic [DIV_D_W-1:0] den,
    output logic               done,
    output logic [DIV_N_W-1:0] quo
);
    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_N_W-1:0] num_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] rem_reg;

    logic [DIV_D_W:0]   rem_sh;
    logic               ge;
    logic [DIV_D_W-1:0] rem_new;

    // one subtract step
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[DIV_N_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_new = ge ? DIV_D_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_D_W-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(DIV_N_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DIV_N_W - 1))
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // dividend register fills with quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_N_W-2:0], ge};
            rem_reg <= rem_new;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

/* design/kernel_width_quantile_estimator.sv */
// kernel width quantile estimator: top level with sequencer, stores and shared multiplier
// depends on kwqe_pkg, kwqe_sqrt, kwqe_div and the assertion macro header
//
// Usage
//   Input channel (in_valid/in_stall): func 0 loads one coordinate of the current point
//   with its class label; last_coord ends the point, last_point ends the set. func 1 is
//   a query with a Q1.16 quantile and gives one result on the output channel
//   (out_valid/out_stall): sigma Q11.8, gamma Q8.24, empty_set, gamma_saturated.
//   The column mask register is written over cfg_valid/cfg_ready while the block is idle.
// Sequence
//   A load that ends a short point zero-fills the remaining columns in the fill state.
//   Closing a set runs the pairwise pass: per pair both labels are read, and per cross-label
//   pair the squares are summed over the sixteen columns and the distance is placed by
//   an insertion sort, all on the one distance memory and the shared multiplier.
//   A query takes no root on an empty set, one 19-step root, or two when it interpolates,
//   then a 40-step divide for gamma (skipped for zero sigma).
//   in_stall is high for the whole of that work.
// Reset and stalls
//   Reset empties the point buffer and the distance list; a query before any set
//   returns sigma 1.0. A finished result waits in the output register while out_stall
//   is high; loads are still taken, a further query waits at its end.
`include "kernel_width_quantile_estimator_macros.svh"

module kernel_width_quantile_estimator import kwqe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DIMS   = MAX_DIMS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic signed [COORD_W-1:0] coord_value,
    input  logic [LABEL_W-1:0]        class_label,
    input  logic                      last_coord,
    input  logic                      last_point,
    input  logic [QUANT_W-1:0]        quantile,
    // output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SIGMA_W-1:0]        sigma,
    output logic [GAMMA_W-1:0]        gamma,
    output logic                      empty_set,
    output logic                      gamma_saturated,
    // configuration channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [MASK_W-1:0]         column_mask
);
    localparam int PW     = $clog2(MAX_POINTS);
    localparam int PCW    = $clog2(MAX_POINTS + 1);
    localparam int DCW    = $clog2(MAX_DIMS + 1);
    localparam int NCOL   = (MAX_DIMS < MASK_W) ? MAX_DIMS : MASK_W;
    localparam int SDEPTH = MAX_POINTS * MAX_DIMS;
    localparam int SAW    = $clog2(SDEPTH);
    localparam int LDEPTH = MAX_POINTS * (MAX_POINTS - 1) / 2;
    localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int CW     = $clog2(LDEPTH + 1);

    // memories
    logic signed [COORD_W-1:0] point_mem [SDEPTH];
    logic [LABEL_W-1:0]        label_mem [MAX_POINTS];
    logic [DIST_W-1:0]         dist_mem  [LDEPTH];

    // control registers
    state_t             state_reg, state_next;
    logic [MASK_W-1:0]  mask_reg;
    logic [PCW-1:0]     pt_cnt_reg;
    logic [DCW-1:0]     ci_reg;
    logic               set_ready_reg;
    logic [CW-1:0]      dcount_reg;
    logic               build_reg;
    logic               out_valid_reg;

    // payload registers
    logic [PW-1:0]        fill_pt_reg;
    logic [DCW-1:0]       fill_col_reg;
    logic [PCW-1:0]       n_reg;
    logic [PCW-1:0]       i_reg;
    logic [PCW-1:0]       j_reg;
    logic [DCW-1:0]       col_reg;
    logic [LABEL_W-1:0]   lab_i_reg;
    logic [DIST_W-1:0]    acc_reg;
    logic [CW-1:0]        k_reg;
    logic [PROD_W-1:0]    mul_reg;
    logic [PROD_W-1:0]    p1_reg;
    logic [QUANT_W-1:0]   q_reg;
    logic [CW-1:0]        idx_reg;
    logic [FRAC_W-1:0]    rest_reg;
    logic                 two_reg;
    logic                 empty_reg;
    logic [SIGMA_W-1:0]   a_reg;
    logic [SIGMA_W-1:0]   b_reg;
    logic [SIGMA_W-1:0]   s_reg;
    logic [GAMMA_W-1:0]   g_reg;
    logic                 sat_reg;
    logic [SIGMA_W-1:0]   sigma_reg;
    logic [GAMMA_W-1:0]   gamma_reg;
    logic                 empty_out_reg;
    logic                 sat_out_reg;

    // memory read data
    logic signed [COORD_W-1:0] pa_q_reg;
    logic signed [COORD_W-1:0] pb_q_reg;
    logic [LABEL_W-1:0]        lab_q_reg;
    logic [DIST_W-1:0]         dist_q_reg;

    // handshakes
    logic in_fire;
    logic load_fire;
    logic query_fire;
    logic out_fire;
    logic cfg_fire;
    logic pt_room;
    logic item_end;
    logic need_fill;

    // memory ports
    logic                      pw_en;
    logic [SAW-1:0]            pw_addr;
    logic signed [COORD_W-1:0] pw_data;
    logic [SAW-1:0]            pa_addr;
    logic [SAW-1:0]            pb_addr;
    logic                      lw_en;
    logic [PW-1:0]             lr_addr;
    logic                      dw_en;
    logic [LAW-1:0]            dw_addr;
    logic [DIST_W-1:0]         dw_data;
    logic [LAW-1:0]            dr_addr;

    // shared multiplier and iterative units
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [PROD_W-1:0]    mul_prod;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]     abs_diff;
    logic                 sq_start;
    logic [DIST_W-1:0]    sq_src;
    logic                 sq_done;
    logic [SIGMA_W-1:0]   sq_root;
    logic                 dv_start;
    logic                 dv_done;
    logic [DIV_N_W-1:0]   dv_quo;
    logic [PROD_W:0]      interp_sum;
    logic [CW:0]          idx_chk;

    // point store address
    function automatic logic [SAW-1:0] st_addr(input logic [PW-1:0] pt,
                                               input logic [DCW-1:0] col);
        return SAW'(SAW'(pt) * SAW'(MAX_DIMS) + SAW'(col));
    endfunction

    assign in_fire    = in_valid && !in_stall;
    assign load_fire  = in_fire && (func == FUNC_LOAD);
    assign query_fire = in_fire && (func == FUNC_QUERY);
    assign out_fire   = out_valid_reg && !out_stall;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign pt_room    = pt_cnt_reg < PCW'(MAX_POINTS);
    assign item_end   = last_coord || last_point;
    assign need_fill  = pt_room && ((DCW+1)'(ci_reg) + 1'b1 < (DCW+1)'(MAX_DIMS));

    assign diff     = (COORD_W+1)'(pa_q_reg) - (COORD_W+1)'(pb_q_reg);
    assign abs_diff = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
    assign mul_prod = mul_a * mul_b;
    assign interp_sum = (PROD_W+1)'(p1_reg) + (PROD_W+1)'(mul_reg)
                      + (PROD_W+1)'(FRAC_ONE >> 1);
    assign idx_chk  = (CW+1)'(mul_reg[FRAC_W +: CW]) + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (load_fire)
                begin
                    if (item_end && need_fill)
                        state_next = S_FILL;
                    else if (last_point)
                        state_next = S_B_START;
                end
                else if (query_fire)
                    state_next = S_Q_MUL;
            end
            S_FILL:
            begin
                if (fill_col_reg == DCW'(MAX_DIMS - 1))
                    state_next = build_reg ? S_B_START : S_IDLE;
            end
            S_B_START: state_next = (pt_cnt_reg < PCW'(2)) ? S_B_DONE : S_B_LI;
            S_B_LI:    state_next = S_B_LJ;
            S_B_LJ:    state_next = S_B_CMP;
            S_B_CMP:   state_next = (lab_q_reg == lab_i_reg) ? S_B_NEXT : S_C_RD;
            S_C_RD:    state_next = S_C_SQ;
            S_C_SQ:    state_next = S_C_ACC;
            S_C_ACC:   state_next = (col_reg == DCW'(NCOL - 1)) ? S_I_RD : S_C_RD;
            S_I_RD:    state_next = (k_reg == '0) ? S_B_NEXT : S_I_CMP;
            S_I_CMP:   state_next = (dist_q_reg > acc_reg) ? S_I_RD : S_B_NEXT;
            S_B_NEXT:
            begin
                if ((j_reg + 1'b1 < n_reg) || ((PCW+1)'(i_reg) + 2'd2 < (PCW+1)'(n_reg)))
                    state_next = S_B_LI;
                else
                    state_next = S_B_DONE;
            end
            S_B_DONE:  state_next = S_IDLE;
            S_Q_MUL:
            begin
                if (empty_reg)
                    state_next = S_G_SQ;
                else if (q_reg >= QUANT_ONE)
                    state_next = S_Q_RDA;
                else
                    state_next = S_Q_IDX;
            end
            S_Q_IDX:   state_next = S_Q_RDA;
            S_Q_RDA:   state_next = S_Q_SQA;
            S_Q_SQA:   state_next = S_Q_WA;
            S_Q_WA:
            begin
                if (sq_done)
                    state_next = two_reg ? S_Q_RDB : S_G_SQ;
            end
            S_Q_RDB:   state_next = S_Q_SQB;
            S_Q_SQB:   state_next = S_Q_WB;
            S_Q_WB:    state_next = sq_done ? S_Q_M1 : S_Q_WB;
            S_Q_M1:    state_next = S_Q_M2;
            S_Q_M2:    state_next = S_Q_SUM;
            S_Q_SUM:   state_next = S_G_SQ;
            S_G_SQ:    state_next = (s_reg == '0) ? S_OUT : S_G_DIV;
            S_G_DIV:   state_next = S_G_WAIT;
            S_G_WAIT:  state_next = dv_done ? S_OUT : S_G_WAIT;
            S_OUT:     state_next = (!out_valid_reg || !out_stall) ? S_IDLE : S_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: memory ports, multiplier operands, unit starts
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        cfg_ready = (state_reg == S_IDLE);
        pw_en     = 1'b0;
        pw_addr   = st_addr(pt_cnt_reg[PW-1:0], ci_reg);
        pw_data   = coord_value;
        pa_addr   = st_addr(i_reg[PW-1:0], col_reg);
        pb_addr   = st_addr(j_reg[PW-1:0], col_reg);
        lw_en     = 1'b0;
        lr_addr   = i_reg[PW-1:0];
        dw_en     = 1'b0;
        dw_addr   = k_reg[LAW-1:0];
        dw_data   = acc_reg;
        dr_addr   = LAW'(k_reg - 1'b1);
        mul_a     = '0;
        mul_b     = '0;
        sq_start  = 1'b0;
        sq_src    = dist_q_reg;
        dv_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                pw_en = load_fire && pt_room && (ci_reg < DCW'(MAX_DIMS));
                lw_en = load_fire && pt_room;
            end
            S_FILL:
            begin
                pw_en   = 1'b1;
                pw_addr = st_addr(fill_pt_reg, fill_col_reg);
                pw_data = '0;
            end
            S_B_LJ: lr_addr = j_reg[PW-1:0];
            S_C_SQ:
            begin
                if (col_en(mask_reg, 7'(col_reg)))
                begin
                    mul_a = MUL_W'(abs_diff);
                    mul_b = MUL_W'(abs_diff);
                end
            end
            S_I_RD:
            begin
                if (k_reg == '0)
                begin
                    dw_en   = 1'b1;
                    dw_addr = '0;
                end
            end
            S_I_CMP:
            begin
                dw_en = 1'b1;
                if (dist_q_reg > acc_reg)
                    dw_data = dist_q_reg;
            end
            S_Q_MUL:
            begin
                mul_a = MUL_W'(q_reg[FRAC_W-1:0]);
                mul_b = MUL_W'(CW'(dcount_reg - 1'b1));
            end
            S_Q_RDA: dr_addr = idx_reg[LAW-1:0];
            S_Q_SQA: sq_start = 1'b1;
            S_Q_RDB: dr_addr = LAW'(idx_reg + 1'b1);
            S_Q_SQB: sq_start = 1'b1;
            S_Q_M1:
            begin
                mul_a = MUL_W'(FRAC_ONE - (FRAC_W+1)'(rest_reg));
                mul_b = a_reg;
            end
            S_Q_M2:
            begin
                mul_a = MUL_W'(rest_reg);
                mul_b = b_reg;
            end
            S_G_SQ:
            begin
                mul_a = s_reg;
                mul_b = s_reg;
            end
            S_G_DIV: dv_start = 1'b1;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mask_reg      <= MASK_RESET;
            pt_cnt_reg    <= '0;
            ci_reg        <= '0;
            set_ready_reg <= 1'b0;
            dcount_reg    <= '0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
                mask_reg <= column_mask;
            // point and column counters
            if (load_fire)
            begin
                build_reg <= last_point;
                if (item_end)
                begin
                    if (pt_room)
                        pt_cnt_reg <= pt_cnt_reg + 1'b1;
                    ci_reg <= '0;
                end
                else if (ci_reg < DCW'(MAX_DIMS))
                    ci_reg <= ci_reg + 1'b1;
            end
            if (state_reg == S_B_START)
            begin
                pt_cnt_reg <= '0;
                ci_reg     <= '0;
                dcount_reg <= '0;
            end
            if (state_reg == S_B_DONE)
                set_ready_reg <= 1'b1;
            // list grows by one when an insertion lands
            if ((state_reg == S_I_RD && k_reg == '0)
                || (state_reg == S_I_CMP && !(dist_q_reg > acc_reg)))
                dcount_reg <= dcount_reg + 1'b1;
            // output register
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_prod;
        case (state_reg)
            S_IDLE:
            begin
                fill_pt_reg  <= pt_cnt_reg[PW-1:0];
                fill_col_reg <= DCW'(ci_reg + 1'b1);
                q_reg        <= quantile;
                empty_reg    <= !set_ready_reg || (dcount_reg == '0);
            end
            S_FILL: fill_col_reg <= fill_col_reg + 1'b1;
            S_B_START:
            begin
                n_reg <= pt_cnt_reg;
                i_reg <= '0;
                j_reg <= PCW'(1);
            end
            S_B_LJ: lab_i_reg <= lab_q_reg;
            S_B_CMP:
            begin
                col_reg <= '0;
                acc_reg <= '0;
            end
            S_C_ACC:
            begin
                acc_reg <= acc_reg + DIST_W'(mul_reg);
                col_reg <= col_reg + 1'b1;
                k_reg   <= dcount_reg;
            end
            S_I_CMP:
            begin
                if (dist_q_reg > acc_reg)
                    k_reg <= k_reg - 1'b1;
            end
            S_B_NEXT:
            begin
                if (j_reg + 1'b1 < n_reg)
                    j_reg <= j_reg + 1'b1;
                else
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + 2'd2;
                end
            end
            S_Q_MUL:
            begin
                if (empty_reg)
                    s_reg <= SIGMA_ONE;
                idx_reg <= CW'(dcount_reg - 1'b1);
                two_reg <= 1'b0;
            end
            S_Q_IDX:
            begin
                idx_reg  <= mul_reg[FRAC_W +: CW];
                rest_reg <= mul_reg[FRAC_W-1:0];
                two_reg  <= (mul_reg[FRAC_W-1:0] != '0) && (idx_chk < (CW+1)'(dcount_reg));
            end
            S_Q_WA:
            begin
                a_reg <= sq_root;
                s_reg <= sq_root;
            end
            S_Q_WB:  b_reg <= sq_root;
            S_Q_M2:  p1_reg <= mul_reg;
            S_Q_SUM: s_reg <= interp_sum[FRAC_W +: SIGMA_W];
            S_G_SQ:
            begin
                g_reg   <= GAMMA_MAX;
                sat_reg <= 1'b1;
            end
            S_G_WAIT:
            begin
                if (dv_quo[DIV_N_W-1:GAMMA_W] != '0)
                begin
                    g_reg   <= GAMMA_MAX;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    g_reg   <= dv_quo[GAMMA_W-1:0];
                    sat_reg <= 1'b0;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    sigma_reg     <= s_reg;
                    gamma_reg     <= g_reg;
                    empty_out_reg <= empty_reg;
                    sat_out_reg   <= sat_reg;
                end
            end
            default: ;
        endcase
    end

    // point store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (pw_en)
            point_mem[pw_addr] <= pw_data;
        pa_q_reg <= point_mem[pa_addr];
        pb_q_reg <= point_mem[pb_addr];
    end

    // label store
    always_ff @(posedge clk)
    begin
        if (lw_en)
            label_mem[pt_cnt_reg[PW-1:0]] <= class_label;
        lab_q_reg <= label_mem[lr_addr];
    end

    // sorted distance list
    always_ff @(posedge clk)
    begin
        if (dw_en)
            dist_mem[dw_addr] <= dw_data;
        dist_q_reg <= dist_mem[dr_addr];
    end

    // square root unit
    kwqe_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (SQRT_IN_W'(sq_src)),
        .done  (sq_done),
        .root  (sq_root)
    );

    // divider for gamma
    kwqe_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (GAMMA_NUM + DIV_N_W'(mul_reg >> 1)),
        .den   (DIV_D_W'(mul_reg)),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    assign out_valid       = out_valid_reg;
    assign sigma           = sigma_reg;
    assign gamma           = gamma_reg;
    assign empty_set       = empty_out_reg;
    assign gamma_saturated = sat_out_reg;

    // checks
    `KWQE_ASSERT_SAME(a_out_from_seq, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_OUT), "result raised outside output state")
    `KWQE_ASSERT_SAME(a_dcount_range, clk, rst_n, 1'b1, dcount_reg <= CW'(LDEPTH), "distance count beyond list depth")
    `KWQE_ASSERT_SAME(a_pt_range, clk, rst_n, 1'b1, pt_cnt_reg <= PCW'(MAX_POINTS), "point count beyond capacity")
    `KWQE_ASSERT_SAME(a_sqrt_done, clk, rst_n, sq_done, (state_reg == S_Q_WA || state_reg == S_Q_WB), "root finished while not awaited")
    `KWQE_ASSERT_NEXT(a_div_start, clk, rst_n, dv_start, state_reg == S_G_WAIT, "divide started without wait state")

endmodule

/* tb/testbench.sv */
// self-checking testbench for the kernel width quantile estimator
// depends on kwqe_pkg and the kernel_width_quantile_estimator top level
module testbench;
    import kwqe_pkg::*;

    localparam int NPTS  = 64;
    localparam int NDIMS = 16;

    typedef struct {
        logic                      func;
        logic signed [COORD_W-1:0] coord;
        logic [LABEL_W-1:0]        label;
        logic                      lc;
        logic                      lp;
        logic [QUANT_W-1:0]        q;
    } item_t;

    typedef struct {
        logic [SIGMA_W-1:0] sigma;
        logic [GAMMA_W-1:0] gamma;
        logic               empty;
        logic               sat;
    } width_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic func;
    logic signed [COORD_W-1:0] coord_value;
    logic [LABEL_W-1:0] class_label;
    logic last_coord;
    logic last_point;
    logic [QUANT_W-1:0] quantile;
    logic out_valid;
    logic out_stall;
    logic [SIGMA_W-1:0] sigma;
    logic [GAMMA_W-1:0] gamma;
    logic empty_set;
    logic gamma_saturated;
    logic cfg_valid;
    logic cfg_ready;
    logic [MASK_W-1:0] column_mask;

    // predictor state
    logic signed [COORD_W-1:0] pt_mem [NPTS][NDIMS];
    logic [LABEL_W-1:0]        lab_mem [NPTS];
    logic [DIST_W-1:0]         sorted_dist [$];
    int                        pt_cnt;
    int                        col_idx;
    bit                        set_closed;
    logic [MASK_W-1:0]         mask_reg;

    width_t expected_widths [$];
    int     errors;
    int     n_items;
    int     n_queries;
    int     n_results;
    int     n_sets;
    bit     quiet;

    kernel_width_quantile_estimator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .coord_value(coord_value), .class_label(class_label),
        .last_coord(last_coord), .last_point(last_point), .quantile(quantile),
        .out_valid(out_valid), .out_stall(out_stall),
        .sigma(sigma), .gamma(gamma), .empty_set(empty_set),
        .gamma_saturated(gamma_saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .column_mask(column_mask)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // rounded square root of a Q.16 distance into Q.8, saturated
    function automatic logic [SIGMA_W-1:0] dist_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        logic [63:0] rem;
        r = 0;
        bitv = 64'd1 << 62;
        rem = x;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= r + bitv)
            begin
                rem = rem - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        if (rem > r)
            r = r + 1;
        return (r > 64'd524287) ? SIGMA_MAX : r[SIGMA_W-1:0];
    endfunction

    // pairwise cross-label distances of the closed set, kept ascending
    task automatic build_sorted_distances();
        logic [63:0] d2;
        int diff;
        int k;
        sorted_dist.delete();
        for (int i = 0; i < pt_cnt; i++)
            for (int j = i + 1; j < pt_cnt; j++)
            begin
                if (lab_mem[i] == lab_mem[j])
                    continue;
                d2 = 0;
                for (int c = 0; c < NDIMS; c++)
                    if (mask_reg[c])
                    begin
                        diff = int'(pt_mem[i][c]) - int'(pt_mem[j][c]);
                        if (diff < 0)
                            diff = -diff;
                        d2 = d2 + 64'(diff) * 64'(diff);
                    end
                k = sorted_dist.size();
                while (k > 0 && sorted_dist[k-1] > d2)
                    k--;
                sorted_dist.insert(k, d2[DIST_W-1:0]);
            end
    endtask

    // kernel width for a quantile from the current distance list
    function automatic width_t width_at(input logic [QUANT_W-1:0] q);
        width_t w;
        logic [63:0] t;
        logic [63:0] rest;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] g;
        int cnt;
        int i;
        cnt = sorted_dist.size();
        w.empty = !set_closed || cnt == 0;
        w.sat = 1'b0;
        if (w.empty)
            s = 256;
        else if (q >= QUANT_ONE)
            s = dist_root(sorted_dist[cnt-1]);
        else
        begin
            t = 64'(q) * 64'(cnt - 1);
            i = int'(t >> 16);
            rest = t & 64'hFFFF;
            a = dist_root(sorted_dist[i]);
            if (rest == 0 || i + 1 >= cnt)
                s = a;
            else
            begin
                b = dist_root(sorted_dist[i+1]);
                s = ((64'd65536 - rest) * a + rest * b + 64'd32768) >> 16;
            end
        end
        if (s == 0)
        begin
            g = 64'hFFFFFFFF;
            w.sat = 1'b1;
        end
        else
        begin
            s2 = s * s;
            g = ((64'd1 << 39) + s2 / 2) / s2;
            if (g > 64'hFFFFFFFF)
            begin
                g = 64'hFFFFFFFF;
                w.sat = 1'b1;
            end
        end
        w.sigma = s[SIGMA_W-1:0];
        w.gamma = g[GAMMA_W-1:0];
        return w;
    endfunction

    // update predictor for one accepted item
    task automatic predict(input item_t it);
        bit fin;
        if (it.func == FUNC_QUERY)
        begin
            expected_widths.insert(expected_widths.size(), width_at(it.q));
            n_queries++;
            return;
        end
        fin = it.lc || it.lp;
        if (pt_cnt < NPTS)
        begin
            if (col_idx < NDIMS)
                pt_mem[pt_cnt][col_idx] = it.coord;
            lab_mem[pt_cnt] = it.label;
        end
        if (fin)
        begin
            if (pt_cnt < NPTS)
            begin
                for (int c = col_idx + 1; c < NDIMS; c++)
                    pt_mem[pt_cnt][c] = '0;
                pt_cnt++;
            end
            col_idx = 0;
        end
        else if (col_idx < NDIMS)
            col_idx++;
        if (it.lp)
        begin
            build_sorted_distances();
            pt_cnt = 0;
            col_idx = 0;
            set_closed = 1'b1;
            n_sets++;
        end
    endtask

    // one input transfer, with an optional random gap in front
    task automatic send_item(input item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= it.func;
        coord_value <= it.coord;
        class_label <= it.label;
        last_coord <= it.lc;
        last_point <= it.lp;
        quantile <= it.q;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict(it);
        n_items++;
    endtask

    task automatic send_query(input logic [QUANT_W-1:0] q);
        item_t it;
        it.func = FUNC_QUERY;
        it.coord = 16'($urandom);
        it.label = 8'($urandom);
        it.lc = 1'($urandom);
        it.lp = 1'($urandom);
        it.q = q;
        send_item(it);
    endtask

    // one point with coordinates drawn from [lo, hi]
    task automatic send_point(input int ndims, input logic [LABEL_W-1:0] lab,
                              input bit closes, input int lo, input int hi);
        item_t it;
        for (int c = 0; c < ndims; c++)
        begin
            it.func = FUNC_LOAD;
            it.coord = 16'(lo + int'($urandom_range(0, hi - lo)));
            it.label = lab;
            it.lc = (c == ndims - 1) ? 1'b1 : (closes ? 1'($urandom) : 1'b0);
            it.lp = closes && (c == ndims - 1);
            it.q = 17'($urandom);
            send_item(it);
        end
    endtask

    // let all results drain, then the block settle before a register write
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_widths.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] m);
        drain();
        cfg_valid <= 1'b1;
        column_mask <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mask_reg = m;
    endtask

    // result checker
    always @(posedge clk)
    begin
        width_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_widths.size() == 0)
            begin
                $display("%0t: unexpected result sigma=%0d gamma=%0d", $time, sigma, gamma);
                errors++;
            end
            else
            begin
                w = expected_widths.pop_front();
                if (sigma !== w.sigma)
                begin
                    $display("%0t: sigma expected %0d actual %0d", $time, w.sigma, sigma);
                    errors++;
                end
                if (gamma !== w.gamma)
                begin
                    $display("%0t: gamma expected %0d actual %0d", $time, w.gamma, gamma);
                    errors++;
                end
                if (empty_set !== w.empty)
                begin
                    $display("%0t: empty_set expected %0b actual %0b",
                             $time, w.empty, empty_set);
                    errors++;
                end
                if (gamma_saturated !== w.sat)
                begin
                    $display("%0t: gamma_saturated expected %0b actual %0b",
                             $time, w.sat, gamma_saturated);
                    errors++;
                end
            end
        end
    end

    // output back-pressure in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    // queries before any set, and extreme coordinates and quantiles
    task automatic test_empty_and_extremes();
        send_query(17'd0);
        send_query(QUANT_ONE);
        send_point(NDIMS, 8'd1, 1'b0, -32768, -32768);
        send_point(NDIMS, 8'd255, 1'b1, 32767, 32767);
        send_query(17'd0);
        send_query(17'h1FFFF);
    endtask

    // identical points across labels give a zero width
    task automatic test_zero_width();
        send_point(2, 8'd3, 1'b0, 100, 100);
        send_point(2, 8'd4, 1'b1, 100, 100);
        send_query(17'd32768);
    endtask

    // a set with a single label has no pairs
    task automatic test_single_label();
        send_point(1, 8'd7, 1'b0, -5, 5);
        send_point(1, 8'd7, 1'b1, -5, 5);
        send_query(17'd40000);
    endtask

    // short and over-long points, and a query while a set is still loading
    task automatic test_point_shapes();
        send_point(3, 8'd0, 1'b0, -300, 300);
        send_point(19, 8'd1, 1'b0, -300, 300);
        send_query(17'd65535);
        send_point(1, 8'd2, 1'b1, 0, 1);
        send_query(17'd21845);
    endtask

    // more points than capacity; the last one still closes the set
    task automatic test_capacity();
        send_point(1, 8'd9, 1'b0, -32768, -32768);
        for (int p = 1; p < 66; p++)
            send_point(1, 8'd10, p == 65, -32768 + p * 500, -32768 + p * 500);
        send_query(17'd0);
        send_query(17'd33000);
        send_query(QUANT_ONE);
    endtask

    // column mask settings, extremes included
    task automatic test_masks();
        logic [MASK_W-1:0] masks [4];
        masks = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
        foreach (masks[m])
        begin
            write_mask(masks[m]);
            for (int p = 0; p < 4; p++)
                send_point(16, 8'(p & 1), p == 3, -2000, 2000);
            send_query(17'($urandom_range(0, 65536)));
        end
    endtask

    // random sets and queries
    task automatic test_random();
        int npts;
        int lo;
        int hi;
        int span;
        while (n_items < 1400)
        begin
            if ($urandom_range(0, 4) == 0)
                write_mask(($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom));
            if (n_items > 1150)
                quiet = 1'b1;
            npts = $urandom_range(2, 12);
            case ($urandom_range(0, 2))
                0: span = 2;
                1: span = 300;
                default: span = 32767;
            endcase
            lo = -span;
            hi = (span == 32767) ? 32767 : span;
            for (int p = 0; p < npts; p++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_query(17'($urandom));
                send_point(($urandom_range(0, 7) == 0) ? $urandom_range(17, 20)
                                                       : $urandom_range(1, 16),
                           ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 2)),
                           p == npts - 1, lo, hi);
            end
            repeat ($urandom_range(1, 4))
                send_query(($urandom_range(0, 5) == 0) ? 17'($urandom)
                                                        : 17'($urandom_range(0, 65536)));
        end
    endtask

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_LOAD;
        coord_value = '0;
        class_label = '0;
        last_coord = 1'b0;
        last_point = 1'b0;
        quantile = '0;
        cfg_valid = 1'b0;
        column_mask = MASK_RESET;
        errors = 0;
        n_items = 0;
        n_queries = 0;
        n_results = 0;
        n_sets = 0;
        quiet = 1'b0;
        pt_cnt = 0;
        col_idx = 0;
        set_closed = 1'b0;
        mask_reg = MASK_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_extremes();
        test_zero_width();
        test_single_label();
        test_point_shapes();
        test_capacity();
        test_masks();
        test_random();
        in_valid <= 1'b0;
        while (expected_widths.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d items in %0d sets, %0d queries and %0d results checked",
                 n_items, n_sets, n_queries, n_results);
        if (errors == 0 && expected_widths.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // overall time limit
    initial
    begin
        #60000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/kwqe_pkg.sv
design/kwqe_sqrt.sv
design/kwqe_div.sv
design/kernel_width_quantile_estimator.sv
tb/testbench.sv
